### rtl/calorimeter_muon_classifier_defines.svh
// assertion macros for the calorimeter muon classifier
// every use expects a clock named clk and an active-low reset named rst_n
`ifndef CALORIMETER_MUON_CLASSIFIER_DEFINES_SVH
`define CALORIMETER_MUON_CLASSIFIER_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define CMC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("calorimeter muon classifier check failed");
// next-cycle implication
`define CMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("calorimeter muon classifier check failed");
`else
`define CMC_ASSERT_IMPLY(lbl, ante, cons)
`define CMC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/cmc_pkg.sv
package cmc_pkg;

  // field widths
  localparam int unsigned MomW   = 18;
  localparam int unsigned IdW    = 16;
  localparam int unsigned EnW    = 17;
  localparam int unsigned SumW   = 25;
  localparam int unsigned CntW   = 8;
  localparam int unsigned BrkW   = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 17;

  // datapath widths
  localparam int unsigned MagW   = 18;          // floor sqrt of |p|^2
  localparam int unsigned SqW    = 2 * MomW;    // one square, and the sum of three
  localparam int unsigned RemW   = MagW + 3;    // root remainder after the 2-bit shift
  localparam int unsigned ProdW  = 42;          // scaled sums and window thresholds
  localparam int unsigned StepW  = $clog2(MagW);
  localparam int unsigned NumComp = 3;
  localparam int unsigned CompW  = $clog2(NumComp);

  // window coefficients, everything in MeV scaled by 1e5
  localparam int unsigned ScaleK = 100000;
  localparam int unsigned CoefE  = 40000;
  localparam int unsigned CoefH  = 50000;

  // reset values of the registers
  localparam logic [BrkW-1:0] EcalBreakRst = BrkW'(10000);
  localparam logic [BrkW-1:0] HcalBreakRst = BrkW'(5000);
  localparam logic [CntW-1:0] EcalLimitRst = CntW'(6);
  localparam logic [CntW-1:0] HcalLimitRst = CntW'(9);

  // item codes
  localparam logic ModeTrack = 1'b0;
  localparam logic ModeHit   = 1'b1;
  localparam logic CaloEcal  = 1'b0;
  localparam logic CaloHcal  = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ECAL_BREAK = 2'd0,
    CFG_HCAL_BREAK = 2'd1,
    CFG_ECAL_LIMIT = 2'd2,
    CFG_HCAL_LIMIT = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAG,
    S_TLOAD,
    S_TMUL,
    S_ELOAD,
    S_EMUL,
    S_EMIT
  } top_state_t;

  typedef enum logic [1:0] {
    MAG_IDLE,
    MAG_SQ,
    MAG_ROOT
  } mag_state_t;

  function automatic logic [MomW-1:0] mom_abs(input logic [MomW-1:0] v);
    mom_abs = v[MomW-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

### rtl/calorimeter_muon_classifier.sv
// calorimeter muon classifier: a track start (mode 0) loads the track id, clears the
// ecal/hcal energy sums and hit counts and forms |p| = floor(sqrt(px^2+py^2+pz^2)) in MeV;
// hits (mode 1) whose associated id matches the track add their energy (saturating at
// -2^24 and 2^24-1) and one count (saturating at 255) to their calorimeter. an item with
// last set produces one result: is_muon plus both hit counts. the e/p windows are tested
// exactly by cross-multiplication; zero momentum always fails. a hit without last leaves
// the block idle, so hits stream back to back. a track start stalls the input until the
// three shift-add squares, the root (two radicand bits a cycle), the serial window-threshold
// multiply and the control states are done. a last adds a 1-bit-per-cycle multiply of
// both sums by 1e5, and the result then waits in the output register until out_stall
// drops; while a result waits, new items are still taken unless another last needs the
// register.
`include "calorimeter_muon_classifier_defines.svh"

module calorimeter_muon_classifier (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_mode,
  input  logic signed [cmc_pkg::MomW-1:0] in_mom_x,
  input  logic signed [cmc_pkg::MomW-1:0] in_mom_y,
  input  logic signed [cmc_pkg::MomW-1:0] in_mom_z,
  input  logic [cmc_pkg::IdW-1:0]      in_track_id,
  input  logic                         in_hit_calo,
  input  logic signed [cmc_pkg::EnW-1:0] in_hit_energy,
  input  logic [cmc_pkg::IdW-1:0]      in_hit_assoc_id,
  input  logic                         in_last,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_is_muon,
  output logic [cmc_pkg::CntW-1:0]     out_ecal_hit_count,
  output logic [cmc_pkg::CntW-1:0]     out_hcal_hit_count,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cmc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cmc_pkg::CfgDatW-1:0]  cfg_data
);

  localparam logic [cmc_pkg::StepW-1:0] MulLast = cmc_pkg::StepW'(cmc_pkg::MagW - 1);
  localparam logic [cmc_pkg::CntW-1:0]  CntMax  = '1;

  // control strobes from the sequencer
  typedef struct packed {
    logic trk_load;   // track start transfer
    logic hit_add;    // matching hit transfer
    logic mul_load;   // load the serial multiplier
    logic mul_scale;  // load it with the sums (else with the window coefficients)
    logic mul_run;    // one multiplier bit
    logic thr_cap;    // keep the finished window thresholds
    logic emit;       // write the output register
  } ctl_t;

  ctl_t ctl;

  cmc_pkg::top_state_t state_r, state_nxt;

  // configuration
  logic [cmc_pkg::BrkW-1:0] ecal_brk_r, hcal_brk_r;
  logic [cmc_pkg::CntW-1:0] ecal_lim_r, hcal_lim_r;

  // per-track state
  logic [cmc_pkg::IdW-1:0]         track_r;
  logic signed [cmc_pkg::SumW-1:0] ecal_sum_r, hcal_sum_r;
  logic [cmc_pkg::CntW-1:0]        ecal_cnt_r, hcal_cnt_r;
  logic                            last_r;

  // magnitude unit
  logic                     mag_busy;
  logic [cmc_pkg::MagW-1:0] mag;

  // serial multiplier, two lanes sharing one multiplier bit stream
  logic [cmc_pkg::StepW-1:0]        mul_cnt_r;
  logic [cmc_pkg::MagW-1:0]         mr_r;
  logic signed [cmc_pkg::ProdW-1:0] mc0_r, mc1_r, acc0_r, acc1_r;
  logic signed [cmc_pkg::ProdW-1:0] acc0_nxt, acc1_nxt;
  logic signed [cmc_pkg::ProdW-1:0] te_r, th_r;
  logic                             mul_done;

  logic in_xfer, out_free, id_match;

  // hit accumulation
  logic signed [cmc_pkg::SumW:0]   add_sum;
  logic signed [cmc_pkg::SumW-1:0] sat_sum;
  logic [cmc_pkg::CntW-1:0]        cnt_sel, cnt_inc;

  // decision
  logic signed [cmc_pkg::ProdW-1:0] p_ext, e_ext, h_ext, e10, h20, h2, k_e, k_h;
  logic ecal_ok, hcal_ok, is_muon;

  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign id_match  = (in_hit_assoc_id == track_r);
  assign mul_done  = (mul_cnt_r == MulLast);
  assign in_stall  = (state_r != cmc_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cmc_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_mode == cmc_pkg::ModeTrack) state_nxt = cmc_pkg::S_MAG;
          else if (in_last)                  state_nxt = cmc_pkg::S_ELOAD;
        end
      end
      cmc_pkg::S_MAG:   if (!mag_busy) state_nxt = cmc_pkg::S_TLOAD;
      cmc_pkg::S_TLOAD: state_nxt = cmc_pkg::S_TMUL;
      cmc_pkg::S_TMUL: begin
        if (mul_done) state_nxt = last_r ? cmc_pkg::S_ELOAD : cmc_pkg::S_IDLE;
      end
      cmc_pkg::S_ELOAD: state_nxt = cmc_pkg::S_EMUL;
      cmc_pkg::S_EMUL:  if (mul_done) state_nxt = cmc_pkg::S_EMIT;
      cmc_pkg::S_EMIT:  if (out_free) state_nxt = cmc_pkg::S_IDLE;
      default:          state_nxt = cmc_pkg::S_IDLE;
    endcase
  end

  // sequencer: strobes
  always_comb begin
    ctl = '0;
    case (state_r)
      cmc_pkg::S_IDLE: begin
        ctl.trk_load = in_xfer && (in_mode == cmc_pkg::ModeTrack);
        ctl.hit_add  = in_xfer && (in_mode == cmc_pkg::ModeHit) && id_match;
      end
      cmc_pkg::S_TLOAD: ctl.mul_load = 1'b1;
      cmc_pkg::S_TMUL: begin
        ctl.mul_run = 1'b1;
        ctl.thr_cap = mul_done;
      end
      cmc_pkg::S_ELOAD: begin
        ctl.mul_load  = 1'b1;
        ctl.mul_scale = 1'b1;
      end
      cmc_pkg::S_EMUL: ctl.mul_run = 1'b1;
      cmc_pkg::S_EMIT: ctl.emit = out_free;
      default: ;
    endcase
  end

  cmc_mag u_mag (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (ctl.trk_load),
    .mom_x_i (in_mom_x),
    .mom_y_i (in_mom_y),
    .mom_z_i (in_mom_z),
    .busy_o  (mag_busy),
    .mag_o   (mag)
  );

  // saturating add of the hit energy into the sum of its calorimeter
  always_comb begin
    add_sum = (in_hit_calo == cmc_pkg::CaloEcal)
            ? ((cmc_pkg::SumW+1)'(ecal_sum_r) + (cmc_pkg::SumW+1)'(in_hit_energy))
            : ((cmc_pkg::SumW+1)'(hcal_sum_r) + (cmc_pkg::SumW+1)'(in_hit_energy));
    if (add_sum[cmc_pkg::SumW] != add_sum[cmc_pkg::SumW-1])
      sat_sum = add_sum[cmc_pkg::SumW] ? {1'b1, {(cmc_pkg::SumW-1){1'b0}}}
                                       : {1'b0, {(cmc_pkg::SumW-1){1'b1}}};
    else
      sat_sum = add_sum[cmc_pkg::SumW-1:0];
    cnt_sel = (in_hit_calo == cmc_pkg::CaloEcal) ? ecal_cnt_r : hcal_cnt_r;
    cnt_inc = (cnt_sel == CntMax) ? cnt_sel : cnt_sel + 1'b1;
  end

  // config and track state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cmc_pkg::S_IDLE;
      ecal_brk_r <= cmc_pkg::EcalBreakRst;
      hcal_brk_r <= cmc_pkg::HcalBreakRst;
      ecal_lim_r <= cmc_pkg::EcalLimitRst;
      hcal_lim_r <= cmc_pkg::HcalLimitRst;
      track_r    <= '0;
      ecal_sum_r <= '0;
      hcal_sum_r <= '0;
      ecal_cnt_r <= '0;
      hcal_cnt_r <= '0;
      last_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cmc_pkg::cfg_reg_t'(cfg_index))
          cmc_pkg::CFG_ECAL_BREAK: ecal_brk_r <= cfg_data[cmc_pkg::BrkW-1:0];
          cmc_pkg::CFG_HCAL_BREAK: hcal_brk_r <= cfg_data[cmc_pkg::BrkW-1:0];
          cmc_pkg::CFG_ECAL_LIMIT: ecal_lim_r <= cfg_data[cmc_pkg::CntW-1:0];
          cmc_pkg::CFG_HCAL_LIMIT: hcal_lim_r <= cfg_data[cmc_pkg::CntW-1:0];
          default: ;
        endcase
      end
      if (ctl.trk_load) begin
        track_r    <= in_track_id;
        ecal_sum_r <= '0;
        hcal_sum_r <= '0;
        ecal_cnt_r <= '0;
        hcal_cnt_r <= '0;
        last_r     <= in_last;
      end else if (ctl.hit_add) begin
        if (in_hit_calo == cmc_pkg::CaloEcal) begin
          ecal_sum_r <= sat_sum;
          ecal_cnt_r <= cnt_inc;
        end else begin
          hcal_sum_r <= sat_sum;
          hcal_cnt_r <= cnt_inc;
        end
      end
    end
  end

  // window coefficients: 40000 - 3p and 50000 - 9p, later multiplied by p
  always_comb begin
    p_ext = {{(cmc_pkg::ProdW - cmc_pkg::MagW){1'b0}}, mag};
    k_e   = cmc_pkg::ProdW'(cmc_pkg::CoefE) - (p_ext + (p_ext <<< 1));
    k_h   = cmc_pkg::ProdW'(cmc_pkg::CoefH) - (p_ext + (p_ext <<< 3));
  end

  assign acc0_nxt = acc0_r + (mr_r[0] ? mc0_r : '0);
  assign acc1_nxt = acc1_r + (mr_r[0] ? mc1_r : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_cnt_r <= '0;
    end else if (ctl.mul_load) begin
      mul_cnt_r <= '0;
    end else if (ctl.mul_run) begin
      mul_cnt_r <= mul_cnt_r + 1'b1;
    end
  end

  // serial multiplier datapath, lsb of the multiplier first
  always_ff @(posedge clk) begin
    if (ctl.mul_load) begin
      acc0_r <= '0;
      acc1_r <= '0;
      if (ctl.mul_scale) begin
        mc0_r <= cmc_pkg::ProdW'(ecal_sum_r);
        mc1_r <= cmc_pkg::ProdW'(hcal_sum_r);
        mr_r  <= cmc_pkg::MagW'(cmc_pkg::ScaleK);
      end else begin
        mc0_r <= k_e;
        mc1_r <= k_h;
        mr_r  <= mag;
      end
    end else if (ctl.mul_run) begin
      acc0_r <= acc0_nxt;
      acc1_r <= acc1_nxt;
      mc0_r  <= mc0_r <<< 1;
      mc1_r  <= mc1_r <<< 1;
      mr_r   <= {1'b0, mr_r[cmc_pkg::MagW-1:1]};
    end
    if (ctl.thr_cap) begin
      te_r <= acc0_nxt;
      th_r <= acc1_nxt;
    end
  end

  // cuts: above the break fixed e/p windows, at or below it the p-dependent ones
  always_comb begin
    e_ext = cmc_pkg::ProdW'(ecal_sum_r);
    h_ext = cmc_pkg::ProdW'(hcal_sum_r);
    e10   = (e_ext <<< 3) + (e_ext <<< 1);
    h20   = (h_ext <<< 4) + (h_ext <<< 2);
    h2    = h_ext <<< 1;
    if (mag > {1'b0, ecal_brk_r})
      ecal_ok = !ecal_sum_r[cmc_pkg::SumW-1] && (e10 <= p_ext);
    else if (mag != '0)
      ecal_ok = !ecal_sum_r[cmc_pkg::SumW-1] && (acc0_r <= te_r);
    else
      ecal_ok = 1'b0;
    if (mag > {1'b0, hcal_brk_r})
      hcal_ok = (h20 >= p_ext) && (h2 <= p_ext);
    else if (mag != '0)
      hcal_ok = (acc1_r >= th_r);
    else
      hcal_ok = 1'b0;
    is_muon = ecal_ok && hcal_ok && (ecal_cnt_r < ecal_lim_r) && (hcal_cnt_r < hcal_lim_r);
  end

  // output register, holds a result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_is_muon        <= is_muon;
      out_ecal_hit_count <= ecal_cnt_r;
      out_hcal_hit_count <= hcal_cnt_r;
    end
  end

  // magnitude unit only runs while the sequencer waits on it
  `CMC_ASSERT_IMPLY(a_mag_owned, mag_busy, state_r == cmc_pkg::S_MAG)
  // a matching or unmatched hit with last goes straight to scaling the sums
  `CMC_ASSERT_NEXT(a_hit_last, in_xfer && in_mode == cmc_pkg::ModeHit && in_last,
    state_r == cmc_pkg::S_ELOAD)
  // a decision with the register free always shows up as a valid result
  `CMC_ASSERT_NEXT(a_emit, state_r == cmc_pkg::S_EMIT && out_free, out_valid)

endmodule

### rtl/cmc_mag.sv
// serial momentum magnitude: sum of squares by shift-add, then a 2-bit-per-cycle root
module cmc_mag (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start_i,
  input  logic [cmc_pkg::MomW-1:0]  mom_x_i,
  input  logic [cmc_pkg::MomW-1:0]  mom_y_i,
  input  logic [cmc_pkg::MomW-1:0]  mom_z_i,
  output logic                      busy_o,
  output logic [cmc_pkg::MagW-1:0]  mag_o
);

  localparam logic [cmc_pkg::StepW-1:0] SqLast   = cmc_pkg::StepW'(cmc_pkg::MomW - 1);
  localparam logic [cmc_pkg::StepW-1:0] RootLast = cmc_pkg::StepW'(cmc_pkg::MagW - 1);
  localparam logic [cmc_pkg::CompW-1:0] CompLast = cmc_pkg::CompW'(cmc_pkg::NumComp - 1);

  cmc_pkg::mag_state_t state_r, state_nxt;

  logic [cmc_pkg::StepW-1:0] step_r;
  logic [cmc_pkg::CompW-1:0] comp_r;
  logic [cmc_pkg::MomW-1:0]  q1_r, q2_r;
  logic [cmc_pkg::SqW-1:0]   mc_r;
  logic [cmc_pkg::MomW-1:0]  mr_r;
  logic [cmc_pkg::SqW-1:0]   sq_r;
  logic [cmc_pkg::RemW-1:0]  rem_r;
  logic [cmc_pkg::MagW-1:0]  root_r;

  logic sq_load, sq_step, sq_next, root_init, root_step;
  logic step_end;

  logic [cmc_pkg::RemW-1:0] rem_sh, trial, rem_nxt;
  logic                     ge;

  assign step_end = (state_r == cmc_pkg::MAG_SQ) ? (step_r == SqLast) : (step_r == RootLast);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cmc_pkg::MAG_IDLE: if (start_i) state_nxt = cmc_pkg::MAG_SQ;
      cmc_pkg::MAG_SQ:   if (step_end && comp_r == CompLast) state_nxt = cmc_pkg::MAG_ROOT;
      cmc_pkg::MAG_ROOT: if (step_end) state_nxt = cmc_pkg::MAG_IDLE;
      default:           state_nxt = cmc_pkg::MAG_IDLE;
    endcase
  end

  // control
  always_comb begin
    sq_load   = 1'b0;
    sq_step   = 1'b0;
    sq_next   = 1'b0;
    root_init = 1'b0;
    root_step = 1'b0;
    case (state_r)
      cmc_pkg::MAG_IDLE: sq_load = start_i;
      cmc_pkg::MAG_SQ: begin
        sq_step   = 1'b1;
        sq_next   = step_end && (comp_r != CompLast);
        root_init = step_end && (comp_r == CompLast);
      end
      cmc_pkg::MAG_ROOT: root_step = 1'b1;
      default: ;
    endcase
  end

  // one root digit
  always_comb begin
    rem_sh  = {rem_r[cmc_pkg::RemW-3:0], sq_r[cmc_pkg::SqW-1 -: 2]};
    trial   = {{(cmc_pkg::RemW - cmc_pkg::MagW - 2){1'b0}}, root_r, 2'b01};
    ge      = (rem_sh >= trial);
    rem_nxt = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cmc_pkg::MAG_IDLE;
      step_r  <= '0;
      comp_r  <= '0;
      root_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (sq_load) begin
        step_r <= '0;
        comp_r <= '0;
      end else if (sq_next) begin
        step_r <= '0;
        comp_r <= comp_r + 1'b1;
      end else if (root_init) begin
        step_r <= '0;
        root_r <= '0;
      end else if (root_step) begin
        step_r <= step_r + 1'b1;
        root_r <= {root_r[cmc_pkg::MagW-2:0], ge};
      end else if (sq_step) begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  // shift-add square and root datapath
  always_ff @(posedge clk) begin
    if (sq_load) begin
      mc_r <= {{(cmc_pkg::SqW - cmc_pkg::MomW){1'b0}}, cmc_pkg::mom_abs(mom_x_i)};
      mr_r <= cmc_pkg::mom_abs(mom_x_i);
      q1_r <= cmc_pkg::mom_abs(mom_y_i);
      q2_r <= cmc_pkg::mom_abs(mom_z_i);
      sq_r <= '0;
    end else if (sq_step) begin
      sq_r <= sq_r + (mr_r[0] ? mc_r : '0);
      if (sq_next) begin
        mc_r <= {{(cmc_pkg::SqW - cmc_pkg::MomW){1'b0}}, q1_r};
        mr_r <= q1_r;
        q1_r <= q2_r;
      end else begin
        mc_r <= {mc_r[cmc_pkg::SqW-2:0], 1'b0};
        mr_r <= {1'b0, mr_r[cmc_pkg::MomW-1:1]};
      end
      if (root_init) rem_r <= '0;
    end else if (root_step) begin
      rem_r <= rem_nxt;
      sq_r  <= {sq_r[cmc_pkg::SqW-3:0], 2'b00};
    end
  end

  assign busy_o = (state_r != cmc_pkg::MAG_IDLE);
  assign mag_o  = root_r;

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  // longest stretch without any transfer before the run is called hung
  localparam int unsigned IdleLimit = 2000;
  // settle time, longer than a track start and a last keep the block busy
  localparam int unsigned SettleCycles = 150;
  localparam longint SumHi = 64'sd16777215;
  localparam longint SumLo = -64'sd16777216;
  localparam int unsigned CountMax = 255;

  typedef struct {
    logic                            mode;
    logic signed [cmc_pkg::MomW-1:0] px;
    logic signed [cmc_pkg::MomW-1:0] py;
    logic signed [cmc_pkg::MomW-1:0] pz;
    logic [cmc_pkg::IdW-1:0]         tid;
    logic                            calo;
    logic signed [cmc_pkg::EnW-1:0]  energy;
    logic [cmc_pkg::IdW-1:0]         aid;
    logic                            last;
  } calo_item_t;

  typedef struct {
    logic                     muon;
    logic [cmc_pkg::CntW-1:0] ecal_n;
    logic [cmc_pkg::CntW-1:0] hcal_n;
  } decision_t;

  // clock, reset and every block input start at known values
  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            in_mode = cmc_pkg::ModeTrack;
  logic signed [cmc_pkg::MomW-1:0] in_mom_x = '0;
  logic signed [cmc_pkg::MomW-1:0] in_mom_y = '0;
  logic signed [cmc_pkg::MomW-1:0] in_mom_z = '0;
  logic [cmc_pkg::IdW-1:0]         in_track_id = '0;
  logic                            in_hit_calo = cmc_pkg::CaloEcal;
  logic signed [cmc_pkg::EnW-1:0]  in_hit_energy = '0;
  logic [cmc_pkg::IdW-1:0]         in_hit_assoc_id = '0;
  logic                            in_last = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            out_is_muon;
  logic [cmc_pkg::CntW-1:0]        out_ecal_hit_count;
  logic [cmc_pkg::CntW-1:0]        out_hcal_hit_count;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [cmc_pkg::CfgIdxW-1:0]     cfg_index = '0;
  logic [cmc_pkg::CfgDatW-1:0]     cfg_data = '0;

  calorimeter_muon_classifier dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the classifier: loaded track, running sums and counts, registers
  logic [cmc_pkg::MagW-1:0] trk_mag = '0;
  logic [cmc_pkg::IdW-1:0]  trk_id = '0;
  longint                   ecal_e = 0;
  longint                   hcal_e = 0;
  int unsigned              ecal_n = 0;
  int unsigned              hcal_n = 0;
  logic [cmc_pkg::BrkW-1:0] ecal_brk = cmc_pkg::EcalBreakRst;
  logic [cmc_pkg::BrkW-1:0] hcal_brk = cmc_pkg::HcalBreakRst;
  logic [cmc_pkg::CntW-1:0] ecal_lim = cmc_pkg::EcalLimitRst;
  logic [cmc_pkg::CntW-1:0] hcal_lim = cmc_pkg::HcalLimitRst;

  calo_item_t  pending_items[$];
  decision_t   decisions_due[$];
  calo_item_t  cur;
  decision_t   want;

  int unsigned queued = 0;
  int unsigned accepted = 0;
  int unsigned decisions_seen = 0;
  int unsigned muons_seen = 0;
  int unsigned errors = 0;
  int unsigned writes = 0;
  int unsigned settings = 1;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned send_idle_pct = 0;  // chance per transfer of a sender pause
  int unsigned recv_idle_pct = 0;  // chance per cycle of a stall burst
  int unsigned quiet = 0;

  task automatic note_mismatch(input string what);
    $display("%t mismatch: %s", $time, what);
    errors++;
  endtask

  // floor square root, settled one result bit at a time from the top
  function automatic logic [cmc_pkg::MagW-1:0] root_of_sq(input longint sq);
    logic [cmc_pkg::MagW-1:0] r;
    logic [cmc_pkg::MagW-1:0] c;
    longint                   t;
    r = '0;
    for (int b = cmc_pkg::MagW - 1; b >= 0; b--) begin
      c = r;
      c[b] = 1'b1;
      t = c;
      if (t * t <= sq) r = c;
    end
    return r;
  endfunction

  function automatic longint clamp_sum(input longint s);
    if (s > SumHi) return SumHi;
    if (s < SumLo) return SumLo;
    return s;
  endfunction

  // apply one accepted item to the shadow state and queue its decision if it ends a track
  task automatic absorb_item(input calo_item_t it);
    longint    x, y, z, p, pp, e;
    logic      ecal_ok, hcal_ok;
    decision_t d;
    if (it.mode == cmc_pkg::ModeTrack) begin
      x = it.px;
      y = it.py;
      z = it.pz;
      trk_mag = root_of_sq(x * x + y * y + z * z);
      trk_id = it.tid;
      ecal_e = 0;
      hcal_e = 0;
      ecal_n = 0;
      hcal_n = 0;
    end else if (it.aid == trk_id) begin
      e = it.energy;
      if (it.calo == cmc_pkg::CaloEcal) begin
        ecal_e = clamp_sum(ecal_e + e);
        if (ecal_n < CountMax) ecal_n++;
      end else begin
        hcal_e = clamp_sum(hcal_e + e);
        if (hcal_n < CountMax) hcal_n++;
      end
    end
    if (it.last) begin
      p = trk_mag;
      pp = p * p;
      // e/p windows as exact integer cross products, zero momentum never passes
      if (p > longint'(ecal_brk)) begin
        ecal_ok = (ecal_e >= 0) && (10 * ecal_e <= p);
      end else if (p > 0) begin
        ecal_ok = (ecal_e >= 0) && (100000 * ecal_e <= 40000 * p - 3 * pp);
      end else begin
        ecal_ok = 1'b0;
      end
      if (p > longint'(hcal_brk)) begin
        hcal_ok = (20 * hcal_e >= p) && (2 * hcal_e <= p);
      end else if (p > 0) begin
        hcal_ok = (100000 * hcal_e >= 50000 * p - 9 * pp);
      end else begin
        hcal_ok = 1'b0;
      end
      d.muon = ecal_ok && hcal_ok && (ecal_n < ecal_lim) && (hcal_n < hcal_lim);
      d.ecal_n = cmc_pkg::CntW'(ecal_n);
      d.hcal_n = cmc_pkg::CntW'(hcal_n);
      decisions_due.push_back(d);
    end
  endtask

  // input driver: holds the payload while stalled, inserts random pauses after a transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        absorb_item(cur);
        accepted++;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
          send_gap = $urandom_range(1, 11);
      end
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        cur = pending_items.pop_front();
        in_mode <= cur.mode;
        in_mom_x <= cur.px;
        in_mom_y <= cur.py;
        in_mom_z <= cur.pz;
        in_track_id <= cur.tid;
        in_hit_calo <= cur.calo;
        in_hit_energy <= cur.energy;
        in_hit_assoc_id <= cur.aid;
        in_last <= cur.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor: compare each transfer with the oldest decision due, then pick the stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (decisions_due.size() == 0) begin
        note_mismatch("decision with none outstanding");
      end else begin
        want = decisions_due.pop_front();
        if (out_is_muon !== want.muon)
          note_mismatch($sformatf("decision %0d is_muon %b, predicted %b",
                                  decisions_seen, out_is_muon, want.muon));
        if (out_ecal_hit_count !== want.ecal_n)
          note_mismatch($sformatf("decision %0d ecal count %0d, predicted %0d",
                                  decisions_seen, out_ecal_hit_count, want.ecal_n));
        if (out_hcal_hit_count !== want.hcal_n)
          note_mismatch($sformatf("decision %0d hcal count %0d, predicted %0d",
                                  decisions_seen, out_hcal_hit_count, want.hcal_n));
        if (want.muon) muons_seen++;
        decisions_seen++;
      end
    end
    // stall bursts, drawn at random while no burst is running
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
      recv_gap = $urandom_range(10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == IdleLimit) begin
      $display("%t no transfer for %0d cycles, %0d decisions outstanding",
               $time, IdleLimit, decisions_due.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send(input calo_item_t it);
    pending_items.push_back(it);
    queued++;
  endtask

  // unused hit fields carry junk on a track start
  function automatic calo_item_t track_item(input int x, input int y, input int z,
                                            input logic [cmc_pkg::IdW-1:0] id,
                                            input logic last);
    calo_item_t it;
    it.mode = cmc_pkg::ModeTrack;
    it.px = cmc_pkg::MomW'(x);
    it.py = cmc_pkg::MomW'(y);
    it.pz = cmc_pkg::MomW'(z);
    it.tid = id;
    it.calo = 1'($urandom);
    it.energy = cmc_pkg::EnW'($urandom);
    it.aid = cmc_pkg::IdW'($urandom);
    it.last = last;
    return it;
  endfunction

  // unused momentum and track fields carry junk on a hit
  function automatic calo_item_t hit_item(input logic calo, input int energy,
                                          input logic [cmc_pkg::IdW-1:0] id,
                                          input logic last);
    calo_item_t it;
    it.mode = cmc_pkg::ModeHit;
    it.px = cmc_pkg::MomW'($urandom);
    it.py = cmc_pkg::MomW'($urandom);
    it.pz = cmc_pkg::MomW'($urandom);
    it.tid = cmc_pkg::IdW'($urandom);
    it.calo = calo;
    it.energy = cmc_pkg::EnW'(energy);
    it.aid = id;
    it.last = last;
    return it;
  endfunction

  // sender pause: nothing in flight, no decision outstanding
  task automatic wait_drain();
    while (accepted != queued || decisions_due.size() != 0) @(posedge clk);
  endtask

  // one register write, held until the transfer; the caller drops cfg_valid afterwards
  task automatic write_reg(input cmc_pkg::cfg_reg_t idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= cmc_pkg::CfgDatW'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      cmc_pkg::CFG_ECAL_BREAK: ecal_brk = cmc_pkg::BrkW'(val);
      cmc_pkg::CFG_HCAL_BREAK: hcal_brk = cmc_pkg::BrkW'(val);
      cmc_pkg::CFG_ECAL_LIMIT: ecal_lim = cmc_pkg::CntW'(val);
      cmc_pkg::CFG_HCAL_LIMIT: hcal_lim = cmc_pkg::CntW'(val);
      default: ;
    endcase
    writes++;
  endtask

  // registers change only once the block has gone quiet
  task automatic configure(input int unsigned eb, input int unsigned hb,
                           input int unsigned el, input int unsigned hl);
    wait_drain();
    repeat (SettleCycles) @(posedge clk);
    write_reg(cmc_pkg::CFG_ECAL_BREAK, eb);
    write_reg(cmc_pkg::CFG_HCAL_BREAK, hb);
    write_reg(cmc_pkg::CFG_ECAL_LIMIT, el);
    write_reg(cmc_pkg::CFG_HCAL_LIMIT, hl);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // one track: start, up to max_hits hits sized to land around the e/p windows, usually a last
  task automatic random_track(input int unsigned max_hits);
    int unsigned             nh, shape;
    int                      x, y, z, p, ecal_tot, hcal_tot, e;
    logic [cmc_pkg::IdW-1:0] id, hid;
    logic                    calo, ends;
    shape = $urandom_range(15);
    x = 0;
    y = 0;
    z = 0;
    p = 0;
    if (shape == 1 || shape == 2) begin
      // full-range components, big magnitude
      x = $urandom_range(262143) - 131072;
      y = $urandom_range(262143) - 131072;
      z = $urandom_range(262143) - 131072;
      p = 131071;
    end else if (shape > 2) begin
      // mostly along z so the magnitude is steerable around the breaks
      p = (shape < 10) ? $urandom_range(1, 16000) : $urandom_range(1, 131071);
      x = $urandom_range(64) - 32;
      y = $urandom_range(64) - 32;
      z = $urandom_range(1) ? p : -p;
    end
    case ($urandom_range(3))
      0: id = '0;
      1: id = '1;
      default: id = cmc_pkg::IdW'($urandom);
    endcase
    nh = $urandom_range(max_hits);
    ecal_tot = p / 100 * $urandom_range(30);
    hcal_tot = p * $urandom_range(80) / 100;
    ends = ($urandom_range(11) != 0);  // now and then a track never gets its last
    send(track_item(x, y, z, id, (nh == 0 && ends) || $urandom_range(9) == 0));
    for (int unsigned i = 0; i < nh; i++) begin
      calo = 1'($urandom_range(1));
      e = (calo == cmc_pkg::CaloEcal ? ecal_tot : hcal_tot) * 2 / nh;
      e = e + $urandom_range(40) - 20;
      if ($urandom_range(9) == 0) e = $urandom_range(131071) - 65536;
      if (e > 65535) e = 65535;
      hid = ($urandom_range(15) == 0) ? id ^ cmc_pkg::IdW'(1 + $urandom_range(65534)) : id;
      send(hit_item(calo, e, hid, ends && i == nh - 1));
    end
    // stray hits after the track's own hits; those with its id keep adding to the old track
    if ($urandom_range(7) == 0)
      repeat ($urandom_range(1, 3))
        send(hit_item(1'($urandom_range(1)), $urandom_range(131071) - 65536,
                      $urandom_range(1) ? id : cmc_pkg::IdW'($urandom),
                      1'($urandom_range(1))));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset register values
    // hits before any track match the cleared id
    send(hit_item(cmc_pkg::CaloEcal, 5, 16'd0, 1'b0));
    send(hit_item(cmc_pkg::CaloHcal, -1, 16'd0, 1'b1));
    // zero momentum with last on the start itself
    send(track_item(0, 0, 0, 16'd0, 1'b1));
    // largest magnitude, then hits continuing after a decision
    send(track_item(-131072, -131072, -131072, 16'hFFFF, 1'b0));
    send(hit_item(cmc_pkg::CaloHcal, 65535, 16'hFFFF, 1'b1));
    send(hit_item(cmc_pkg::CaloEcal, -65536, 16'hFFFF, 1'b1));
    send(track_item(131071, 131071, 131071, 16'd1, 1'b1));
    wait_drain();
    // muon below both breaks, with one foreign hit ignored
    send(track_item(0, 0, 3000, 16'd7, 1'b0));
    send(hit_item(cmc_pkg::CaloEcal, 200, 16'd7, 1'b0));
    send(hit_item(cmc_pkg::CaloHcal, 800, 16'd7, 1'b0));
    send(hit_item(cmc_pkg::CaloHcal, 5000, 16'd8, 1'b0));
    send(hit_item(cmc_pkg::CaloEcal, 0, 16'd7, 1'b1));
    // muon above both breaks, p = 20000
    send(track_item(12000, -16000, 0, 16'hABCD, 1'b0));
    send(hit_item(cmc_pkg::CaloEcal, 500, 16'hABCD, 1'b0));
    send(hit_item(cmc_pkg::CaloHcal, 3000, 16'hABCD, 1'b1));
    // momentum right on the ecal break, energies on the window edges
    send(track_item(0, 10000, 0, 16'd3, 1'b0));
    send(hit_item(cmc_pkg::CaloEcal, 1000, 16'd3, 1'b0));
    send(hit_item(cmc_pkg::CaloHcal, 500, 16'd3, 1'b1));
    // ecal hit count reaches its limit
    send(track_item(0, 0, 3000, 16'd9, 1'b0));
    repeat (5) send(hit_item(cmc_pkg::CaloEcal, 30, 16'd9, 1'b0));
    send(hit_item(cmc_pkg::CaloEcal, 30, 16'd9, 1'b1));
    wait_drain();

    // mid-range registers, moderate idling
    configure($urandom_range(1000, 30000), $urandom_range(1000, 30000),
              $urandom_range(1, 12), $urandom_range(1, 12));
    send_idle_pct = 25;
    recv_idle_pct = 5;
    while (queued < 100) random_track(12);

    // fixed windows everywhere, loosest count limits, heavy idling
    configure(0, 0, 255, 255);
    send_idle_pct = 50;
    recv_idle_pct = 15;
    while (queued < 150) random_track(12);
    // ecal count and sum run into saturation
    send(track_item(0, 0, 60000, 16'h5A5A, 1'b0));
    repeat (258) send(hit_item(cmc_pkg::CaloEcal, 65535, 16'h5A5A, 1'b0));
    send(hit_item(cmc_pkg::CaloHcal, -65536, 16'h5A5A, 1'b1));

    // widest breaks, zero limits: nothing can pass
    configure(131071, 131071, 0, 0);
    send_idle_pct = 10;
    recv_idle_pct = 3;
    while (queued < 425) random_track(12);

    // last stretch back to bursts of traffic with no idling at all
    configure($urandom_range(5000, 20000), $urandom_range(2000, 10000),
              $urandom_range(4, 10), $urandom_range(6, 14));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (queued < 450) random_track(12);

    wait_drain();
    repeat (SettleCycles) @(posedge clk);
    $display("%0d items sent under %0d register settings (%0d register writes)",
             queued, settings, writes);
    $display("%0d decisions checked, %0d predicted muons, %0d mismatches",
             decisions_seen, muons_seen, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
